### src/smrm_pkg.sv
// shared types and codes for the sorted memory range map
`timescale 1ns / 1ps
`default_nettype none
package smrm_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] size;
    logic [31:0] kind;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_SCAN_CHK = 12'b0000_0000_0010,
    S_SCAN_EV  = 12'b0000_0000_0100,
    S_P2_CHK   = 12'b0000_0000_1000,
    S_P2_EV    = 12'b0000_0001_0000,
    S_FINAL    = 12'b0000_0010_0000,
    S_PUT_CHK  = 12'b0000_0100_0000,
    S_SH_CHK   = 12'b0000_1000_0000,
    S_SH_WR    = 12'b0001_0000_0000,
    S_PUT_WR   = 12'b0010_0000_0000,
    S_READ     = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    C_P2    = 2'd0,
    C_FINAL = 2'd1,
    C_DONE  = 2'd2
  } cont_e;

endpackage
`default_nettype wire

### src/smrm_if.sv
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface smrm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] range_start;
  logic [63:0] range_size;
  logic [31:0] range_kind;
  logic [4:0]  read_index;
  modport source (output valid, req_type, range_start, range_size, range_kind, read_index,
                  input ready);
  modport sink (input valid, req_type, range_start, range_size, range_kind, read_index,
                output ready);
endinterface

interface smrm_rsp_if #(parameter int unsigned CW = 6);
  logic          valid;
  logic          ready;
  logic [63:0]   out_start;
  logic [63:0]   out_size;
  logic [31:0]   out_kind;
  logic          out_valid;
  logic          overflowed;
  logic [CW-1:0] count_now;
  modport source (output valid, out_start, out_size, out_kind, out_valid, overflowed,
                  count_now, input ready);
  modport sink (input valid, out_start, out_size, out_kind, out_valid, overflowed,
                count_now, output ready);
endinterface

interface smrm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] hole_type;
  modport source (output valid, hole_type, input ready);
  modport sink (input valid, hole_type, output ready);
endinterface
`default_nettype wire

### src/sorted_memory_range_map.sv
// sorted memory range table with add, read and clear requests
//
//  channel  dir  handshake     contents
//  req_i    in   valid/ready   req_type, range_start, range_size, range_kind, read_index
//  rsp_o    out  valid/ready   out_start, out_size, out_kind, out_valid, overflowed, count_now
//  cfg_i    in   valid/ready   hole_type
//
// read, clear and zero-size add do not walk the table; an add walks the table one entry
// at a time and moves each shifted entry through the single ram.
// a range that covers the whole table removes the entries one by one, each removal
// shifting the rest down.
// reset empties the table (count zero), hole_type goes to all ones.
// a waiting result holds the next request in its last cycle until rsp_o takes the result.
`timescale 1ns / 1ps
`default_nettype none
module sorted_memory_range_map #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  smrm_req_if.sink   req_i,
  smrm_rsp_if.source rsp_o,
  smrm_cfg_if.sink   cfg_i
);
  import smrm_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IXW = (CW > 5) ? CW : 5;

  state_e        state_q, state_d;
  cont_e         cont_q, cont_d;
  logic          up_q, up_d;
  logic [CW-1:0] i_q, i_d, k_q, k_d, cnt_q, cnt_d;
  logic [63:0]   start_q, start_d, size_q, size_d, end_q, end_d;
  logic [31:0]   kind_q, kind_d, hole_q;
  entry_t        ins_q, ins_d, rdat_q, rdat_d;
  logic          drop_q, drop_d, hit_q, hit_d;

  logic          rsp_valid_q;
  entry_t        out_q;
  logic          out_hit_q, out_drop_q;
  logic [CW-1:0] out_cnt_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rd;
  logic [EntryW-1:0] rdata;
  logic [63:0]   ee;
  logic [IXW-1:0] idx_ext, cnt_ext;

  smrm_ram #(.WIDTH(EntryW), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd      = entry_t'(rdata);
  assign ee      = rd.start + rd.size;
  assign idx_ext = IXW'(req_i.read_index);
  assign cnt_ext = IXW'(cnt_q);

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.out_start  = out_q.start;
  assign rsp_o.out_size   = out_q.size;
  assign rsp_o.out_kind   = out_q.kind;
  assign rsp_o.out_valid  = out_hit_q;
  assign rsp_o.overflowed = out_drop_q;
  assign rsp_o.count_now  = out_cnt_q;

  function automatic state_e cont_state(cont_e c);
    state_e s;
    unique case (c)
      C_P2:    s = S_P2_CHK;
      C_FINAL: s = S_FINAL;
      default: s = S_RESP;
    endcase
    return s;
  endfunction

  always_comb begin
    state_d = state_q;
    cont_d  = cont_q;
    up_d    = up_q;
    i_d     = i_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    size_d  = size_q;
    end_d   = end_q;
    kind_d  = kind_q;
    ins_d   = ins_q;
    rdat_d  = rdat_q;
    drop_d  = drop_q;
    hit_d   = hit_q;
    we      = 1'b0;
    waddr   = i_q[AW-1:0];
    wdata   = rd;
    raddr   = i_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        raddr = AW'(req_i.read_index);
        if (req_i.valid) begin
          rdat_d  = '0;
          hit_d   = 1'b0;
          drop_d  = 1'b0;
          start_d = req_i.range_start;
          size_d  = req_i.range_size;
          end_d   = req_i.range_start + req_i.range_size;
          kind_d  = req_i.range_kind;
          i_d     = '0;
          unique case (req_e'(req_i.req_type))
            REQ_ADD:   state_d = (req_i.range_size == '0) ? S_RESP : S_SCAN_CHK;
            REQ_READ: begin
              hit_d   = (idx_ext < cnt_ext);
              state_d = S_READ;
            end
            REQ_CLEAR: begin
              cnt_d   = '0;
              state_d = S_RESP;
            end
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_READ: begin
        if (hit_q) begin
          rdat_d = rd;
        end
        state_d = S_RESP;
      end
      S_SCAN_CHK: begin
        state_d = (i_q < cnt_q) ? S_SCAN_EV : S_P2_CHK;
      end
      S_SCAN_EV: begin
        if (start_q > ee) begin
          i_d     = i_q + 1'b1;
          state_d = S_SCAN_CHK;
        end else if (start_q > rd.start) begin
          if (kind_q == rd.kind) begin
            start_d = rd.start;
            size_d  = end_q - rd.start;
            state_d = S_P2_CHK;
          end else begin
            we         = 1'b1;
            wdata.size = start_q - rd.start;
            i_d        = i_q + 1'b1;
            if (ee > end_q) begin
              ins_d   = '{start: end_q, size: ee - end_q, kind: rd.kind};
              cont_d  = C_P2;
              state_d = S_PUT_CHK;
            end else begin
              state_d = S_P2_CHK;
            end
          end
        end else begin
          state_d = S_P2_CHK;
        end
      end
      S_P2_CHK: begin
        state_d = (i_q < cnt_q) ? S_P2_EV : S_FINAL;
      end
      S_P2_EV: begin
        if (end_q < rd.start) begin
          state_d = S_FINAL;
        end else if (end_q >= ee) begin
          up_d    = 1'b0;
          k_d     = i_q;
          cont_d  = C_P2;
          state_d = S_SH_CHK;
        end else if (kind_q == rd.kind) begin
          size_d  = rd.start + rd.size - start_q;
          up_d    = 1'b0;
          k_d     = i_q;
          cont_d  = C_FINAL;
          state_d = S_SH_CHK;
        end else begin
          we          = 1'b1;
          wdata.start = end_q;
          wdata.size  = ee - end_q;
          state_d     = S_FINAL;
        end
      end
      S_FINAL: begin
        if (kind_q != hole_q) begin
          ins_d   = '{start: start_q, size: size_q, kind: kind_q};
          cont_d  = C_DONE;
          state_d = S_PUT_CHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_PUT_CHK: begin
        if (cnt_q >= CW'(MAX_ENTRIES)) begin
          drop_d  = 1'b1;
          state_d = cont_state(cont_q);
        end else begin
          up_d    = 1'b1;
          k_d     = cnt_q;
          state_d = S_SH_CHK;
        end
      end
      S_SH_CHK: begin
        if (up_q) begin
          raddr = AW'(k_q - 1'b1);
          state_d = (k_q > i_q) ? S_SH_WR : S_PUT_WR;
        end else begin
          raddr = AW'(k_q + 1'b1);
          if (CW'(k_q + 1'b1) < cnt_q) begin
            state_d = S_SH_WR;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            state_d = cont_state(cont_q);
          end
        end
      end
      S_SH_WR: begin
        we      = 1'b1;
        waddr   = k_q[AW-1:0];
        k_d     = up_q ? k_q - 1'b1 : k_q + 1'b1;
        state_d = S_SH_CHK;
      end
      S_PUT_WR: begin
        we      = 1'b1;
        wdata   = ins_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = cont_state(cont_q);
      end
      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cont_q      <= C_DONE;
      up_q        <= 1'b0;
      cnt_q       <= '0;
      hole_q      <= '1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cont_q  <= cont_d;
      up_q    <= up_d;
      cnt_q   <= cnt_d;
      if (cfg_i.valid) begin
        hole_q <= cfg_i.hole_type;
      end
      if ((state_q == S_RESP) && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    k_q     <= k_d;
    start_q <= start_d;
    size_q  <= size_d;
    end_q   <= end_d;
    kind_q  <= kind_d;
    ins_q   <= ins_d;
    rdat_q  <= rdat_d;
    drop_q  <= drop_d;
    hit_q   <= hit_d;
    if ((state_q == S_RESP) && (!rsp_valid_q || rsp_o.ready)) begin
      out_q      <= rdat_q;
      out_hit_q  <= hit_q;
      out_drop_q <= drop_q;
      out_cnt_q  <= cnt_q;
    end
  end
endmodule
`default_nettype wire

### src/smrm_ram.sv
// generic ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module smrm_ram #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
